// File: hdl/coordinate_compressor_unit_macros.svh
// Assertion macros for the coordinate compressor unit.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef COORDINATE_COMPRESSOR_UNIT_MACROS_SVH
`define COORDINATE_COMPRESSOR_UNIT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define CCU_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define CCU_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/ccu_pkg.sv
// Shared types for the coordinate compressor unit.
// No dependencies; used by the cell, the top module and the testbench.
`timescale 1ns / 1ps

package ccu_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_LOWER   = 2'd1,
		CMD_UPPER   = 2'd2,
		CMD_RESTORE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]               command;
		logic signed [DATA_W-1:0] operand;
		logic                     batch_end;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] answer;
		logic                     run_end;
		logic                     overflow;
	} out_item_t;

	// Flags one cell hands to its right-hand neighbor.
	typedef struct packed {
		logic vld;  // cell holds a value
		logic lt;   // held value is below the broadcast key
		logic eq;   // held value equals the broadcast key
	} cell_link_t;

endpackage

// File: hdl/ccu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ccu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/ccu_cell.sv
// One cell of the sorted distinct-value chain.
// Depends on ccu_pkg for the neighbor link type.
`timescale 1ns / 1ps

module ccu_cell import ccu_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clr,       // treat the chain as empty
	input  logic                    ins,       // insert key this cycle
	input  logic                    hit,       // some cell already holds the key
	input  logic signed [WIDTH-1:0] key,
	input  cell_link_t              left_link,
	input  logic signed [WIDTH-1:0] left_data,
	output cell_link_t              link,
	output logic signed [WIDTH-1:0] data
);

	logic                    vld_q;
	logic signed [WIDTH-1:0] data_q;
	logic                    vld_eff;
	logic                    take_key;
	logic                    take_left;

	assign vld_eff  = vld_q & ~clr;
	assign link.vld = vld_eff;
	assign link.lt  = vld_eff && (data_q < key);
	assign link.eq  = vld_eff && (data_q == key);

	// Take the key where it lands between the left value and ours; shift right
	// when the left value is above the key. An equal value anywhere blocks both.
	assign take_key  = !link.lt && !link.eq && left_link.lt;
	assign take_left = !hit && left_link.vld && !left_link.lt && !left_link.eq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ins) begin
			vld_q <= vld_eff | take_key | take_left;
		end
	end

	always_ff @(posedge clk) begin
		if (ins) begin
			if (take_key) begin
				data_q <= key;
			end else if (take_left) begin
				data_q <= left_data;
			end
		end
	end

	assign data = data_q;

endmodule

// File: hdl/ccu_count.sv
// Turns a thermometer flag vector into the count of its set flags.
// No dependencies.
`timescale 1ns / 1ps

module ccu_count #(
	parameter int N = 64
) (
	input  logic [N-1:0]           therm,
	output logic [$clog2(N+1)-1:0] count
);

	localparam int CW = $clog2(N + 1);

	logic [N:0] edge_hot;

	// Mark the single position where the flags drop from one to zero.
	always_comb begin
		edge_hot[0] = ~therm[0];
		for (int i = 1; i < N; i++) begin
			edge_hot[i] = therm[i-1] & ~therm[i];
		end
		edge_hot[N] = therm[N-1];
	end

	always_comb begin
		count = '0;
		for (int i = 0; i <= N; i++) begin
			if (edge_hot[i]) begin
				count = count | CW'(i);
			end
		end
	end

endmodule

// File: hdl/coordinate_compressor_unit.sv
// Coordinate compressor: loads a batch of values into a sorted chain of cells, then emits
// ranks in input order and answers lower-bound, upper-bound and restore transactions.
// Sequencing: loads are taken while idle and stream back to back; a query or restore passes
// through compare, count and output states, and each rank through read, compare, count and
// output, plus output stall; no new transaction is taken until the last result has left.
// Reset clears the state machine, counters and cell valid flags.
`timescale 1ns / 1ps
`include "coordinate_compressor_unit_macros.svh"

module coordinate_compressor_unit import ccu_pkg::*; #(
	parameter int MAX_ITEMS   = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	// Values are held at their effective width and compared signed.
	localparam int EFF_W = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
	localparam int CW    = $clog2(MAX_ITEMS + 1);
	localparam int AW    = $clog2(MAX_ITEMS);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_CMP  = 5'b00100,
		S_ENC  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t                  state_q;
	cmd_t                    mode_q;      // CMD_LOAD here means rank emission
	logic                    batch_open_q;
	logic                    cut_q;
	logic [CW-1:0]           item_count_q;
	logic [AW-1:0]           rank_idx_q;
	logic signed [EFF_W-1:0] key_q;
	logic [DATA_W-1:0]       restore_rank_q;
	logic [MAX_ITEMS-1:0]    therm_s1;
	logic signed [EFF_W-1:0] restore_s1;
	out_item_t               result_q;

	logic                    accept;
	logic                    load_acc;
	logic                    fresh;
	logic [CW-1:0]           count_eff;
	logic                    room;
	logic                    chain_clr;
	logic                    chain_ins;
	logic signed [EFF_W-1:0] op_eff;
	logic signed [EFF_W-1:0] key;
	logic [EFF_W-1:0]        rd_data;
	logic [CW-1:0]           enc_count;
	logic                    last_rank;
	logic signed [EFF_W-1:0] restore_sel;
	logic [MAX_ITEMS-1:0]    vld_vec;
	logic [MAX_ITEMS-1:0]    eq_vec;
	logic                    key_hit;
	logic [MAX_ITEMS-1:0]    therm;

	cell_link_t              links [MAX_ITEMS+1];
	logic signed [EFF_W-1:0] cell_data [MAX_ITEMS+1];

	// ---------------------------------------------------------------------
	// Input side: a transaction is taken only while idle.
	// ---------------------------------------------------------------------
	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign load_acc   = accept && (cmd_t'(item.command) == CMD_LOAD);
	assign op_eff     = item.operand[EFF_W-1:0];

	// A load with no open batch starts over: counts and chain read as empty.
	assign fresh     = !batch_open_q;
	assign count_eff = fresh ? '0 : item_count_q;
	assign room      = (count_eff < CW'(MAX_ITEMS));
	assign chain_clr = load_acc && fresh;
	assign chain_ins = load_acc && room;

	// Broadcast key: incoming value while idle, stored value during ranks,
	// held query operand otherwise.
	always_comb begin
		key = key_q;
		if (state_q == S_IDLE) begin
			key = op_eff;
		end else if (mode_q == CMD_LOAD) begin
			key = rd_data;
		end
	end

	// ---------------------------------------------------------------------
	// Batch values in arrival order.
	// ---------------------------------------------------------------------
	ccu_ram #(
		.WIDTH (EFF_W),
		.DEPTH (MAX_ITEMS)
	) u_item_ram (
		.clk   (clk),
		.we    (chain_ins),
		.waddr (count_eff[AW-1:0]),
		.wdata (op_eff),
		.re    (state_q == S_READ),
		.raddr (rank_idx_q),
		.rdata (rd_data)
	);

	// ---------------------------------------------------------------------
	// Sorted chain of distinct values; a virtual cell left of the first one
	// stands for minus infinity.
	// ---------------------------------------------------------------------
	assign links[0]     = '{vld: 1'b0, lt: 1'b1, eq: 1'b0};
	assign cell_data[0] = '0;

	// Drop a key that is already held: no cell may shift for it.
	assign key_hit = |eq_vec;

	for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
		ccu_cell #(
			.WIDTH (EFF_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.clr       (chain_clr),
			.ins       (chain_ins),
			.hit       (key_hit),
			.key       (key),
			.left_link (links[g]),
			.left_data (cell_data[g]),
			.link      (links[g+1]),
			.data      (cell_data[g+1])
		);
		assign vld_vec[g] = links[g+1].vld;
		assign eq_vec[g]  = links[g+1].eq;
		// Lower bound counts values below the key; upper bound and equal too.
		assign therm[g]   = links[g+1].lt || (mode_q == CMD_UPPER && links[g+1].eq);
	end

	// Restore picks the cell whose position matches the rank; an empty cell
	// or a rank past the chain reads as zero.
	always_comb begin
		restore_sel = '0;
		for (int i = 0; i < MAX_ITEMS; i++) begin
			if (vld_vec[i] && restore_rank_q == DATA_W'(i)) begin
				restore_sel = restore_sel | cell_data[i+1];
			end
		end
	end

	ccu_count #(
		.N (MAX_ITEMS)
	) u_count (
		.therm (therm_s1),
		.count (enc_count)
	);

	assign last_rank = (CW'(rank_idx_q) + CW'(1)) == item_count_q;

	// ---------------------------------------------------------------------
	// Sequencer.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= CMD_LOAD;
			batch_open_q <= 1'b0;
			cut_q        <= 1'b0;
			item_count_q <= '0;
			rank_idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (load_acc) begin
						item_count_q <= count_eff + CW'(room);
						cut_q        <= (fresh ? 1'b0 : cut_q) | !room;
						batch_open_q <= !item.batch_end;
						if (item.batch_end) begin
							// Close the batch: stream ranks from the first value.
							mode_q     <= CMD_LOAD;
							rank_idx_q <= '0;
							state_q    <= S_READ;
						end
					end else if (accept) begin
						mode_q  <= cmd_t'(item.command);
						state_q <= S_CMP;
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					state_q <= S_ENC;
				end
				S_ENC: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (result_ready) begin
						if (mode_q == CMD_LOAD && !result_q.run_end) begin
							rank_idx_q <= rank_idx_q + AW'(1);
							state_q    <= S_READ;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold query operands; capture chain flags and the restored value; build
	// the result word.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q          <= op_eff;
			restore_rank_q <= item.operand;
		end
		if (state_q == S_CMP) begin
			therm_s1   <= therm;
			restore_s1 <= restore_sel;
		end
		if (state_q == S_ENC) begin
			case (mode_q)
				CMD_LOAD: begin
					result_q.answer   <= DATA_W'(enc_count);
					result_q.run_end  <= last_rank;
					result_q.overflow <= cut_q;
				end
				CMD_LOWER, CMD_UPPER: begin
					result_q.answer   <= DATA_W'(enc_count);
					result_q.run_end  <= 1'b1;
					result_q.overflow <= 1'b0;
				end
				CMD_RESTORE: begin
					result_q.answer   <= DATA_W'(restore_s1);
					result_q.run_end  <= 1'b1;
					result_q.overflow <= 1'b0;
				end
				default: begin
					result_q.answer   <= '0;
					result_q.run_end  <= 1'b1;
					result_q.overflow <= 1'b0;
				end
			endcase
		end
	end

	assign result_valid = (state_q == S_OUT);
	assign result       = result_q;

	// ---------------------------------------------------------------------
	// Checks.
	// ---------------------------------------------------------------------
	`CCU_CHECK(a_chain_packed, (vld_vec & (vld_vec + MAX_ITEMS'(1))) == '0, "chain has a gap")
	`CCU_CHECK(a_count_bound, item_count_q <= CW'(MAX_ITEMS), "item count past capacity")
	`CCU_CHECK(a_one_side, !(item_ready && result_valid), "input taken while result waits")
	`CCU_CHECK_NEXT(a_close_reads, load_acc && item.batch_end, state_q == S_READ, "no rank run")

endmodule

// File: test/tb_coordinate_compressor_unit.sv
// Self-checking testbench for coordinate_compressor_unit: load batches, bound queries, restores.
// Depends on ccu_pkg and the unit RTL; predicts every result in-bench and checks it in order.
`timescale 1ns / 1ps

module tb_coordinate_compressor_unit;
	import ccu_pkg::*;

	localparam int MAX_ITEMS   = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int RANDOM_ITEMS = 400;
	localparam int CALM_TAIL    = 40;   // last items sent with no idling on either side
	localparam int QUIET_LIMIT  = 2000; // cycles with no transaction before giving up
	localparam int END_SETTLE   = 40;   // cycles to watch for stray results at the end

	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	in_item_t  item = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_item_t result;

	coordinate_compressor_unit #(
		.MAX_ITEMS  (MAX_ITEMS),
		.VALUE_WIDTH(VALUE_WIDTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Stimulus store: items waiting to be sent, and a per-item flag that
	// makes the driver hold off until every expected result is back.
	// ------------------------------------------------------------------
	in_item_t queued_items[$];
	bit       hold_for_drain[$];

	// ------------------------------------------------------------------
	// Compressor shadow state, updated at each accepted item transaction.
	// ------------------------------------------------------------------
	logic signed [DATA_W-1:0] kept_values     [MAX_ITEMS];
	logic signed [DATA_W-1:0] sorted_distinct [MAX_ITEMS];
	int        kept_count     = 0;
	int        distinct_total = 0;
	bit        batch_loading  = 1'b0;
	bit        batch_trimmed  = 1'b0;
	out_item_t expected_answers[$];

	int mismatches      = 0;
	int items_sent      = 0;
	int results_checked = 0;
	int batches_closed  = 0;
	int batches_cut     = 0;
	int quiet_cycles    = 0;
	int send_gap        = 0;
	int recv_gap        = 0;
	bit item_fire;

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		mismatches++;
	endtask

	// Count distinct values below v (or at or below v when inclusive is set).
	function automatic int count_lower(input logic signed [DATA_W-1:0] v, input bit inclusive);
		int n;
		n = 0;
		for (int i = 0; i < distinct_total; i++)
			if (sorted_distinct[i] < v || (inclusive && sorted_distinct[i] == v))
				n++;
		return n;
	endfunction

	function automatic void insert_distinct(input logic signed [DATA_W-1:0] v);
		int pos;
		pos = count_lower(v, 1'b0);
		if (pos < distinct_total && sorted_distinct[pos] == v)
			return;
		if (distinct_total >= MAX_ITEMS)
			return;
		for (int i = distinct_total; i > pos; i--)
			sorted_distinct[i] = sorted_distinct[i-1];
		sorted_distinct[pos] = v;
		distinct_total++;
	endfunction

	// Advance the shadow state by one accepted item; queue the results it causes.
	task automatic predict_results(input in_item_t it);
		logic signed [DATA_W-1:0] v;
		logic [DATA_W-1:0]        rank_sel;
		out_item_t                r;
		v        = it.operand;
		rank_sel = it.operand;
		r        = '0;
		case (cmd_t'(it.command))
			CMD_LOAD: begin
				// A load with no open batch starts a fresh one.
				if (!batch_loading) begin
					kept_count     = 0;
					distinct_total = 0;
					batch_trimmed  = 1'b0;
					batch_loading  = 1'b1;
				end
				if (kept_count < MAX_ITEMS) begin
					kept_values[kept_count] = v;
					kept_count++;
					insert_distinct(v);
				end else begin
					batch_trimmed = 1'b1;
				end
				if (it.batch_end) begin
					batch_loading = 1'b0;
					batches_closed++;
					if (batch_trimmed)
						batches_cut++;
					for (int k = 0; k < kept_count; k++) begin
						r.answer   = count_lower(kept_values[k], 1'b0);
						r.run_end  = (k == kept_count - 1);
						r.overflow = batch_trimmed;
						expected_answers.push_back(r);
					end
				end
			end
			CMD_LOWER, CMD_UPPER: begin
				r.answer   = count_lower(v, cmd_t'(it.command) == CMD_UPPER);
				r.run_end  = 1'b1;
				r.overflow = 1'b0;
				expected_answers.push_back(r);
			end
			default: begin
				// Restore: rank is unsigned, anything past the distinct list gives 0.
				r.answer   = (rank_sel < DATA_W'(distinct_total)) ? sorted_distinct[rank_sel] : '0;
				r.run_end  = 1'b1;
				r.overflow = 1'b0;
				expected_answers.push_back(r);
			end
		endcase
	endtask

	function automatic void queue_item(input cmd_t c, input logic [DATA_W-1:0] v, input bit last,
					  input bit drain);
		in_item_t it;
		it.command   = c;
		it.operand   = v;
		it.batch_end = last;
		queued_items.push_back(it);
		hold_for_drain.push_back(drain);
	endfunction

	// Mix duplicates from a narrow pool, the extremes, and full-range values.
	function automatic logic [DATA_W-1:0] pick_value(input int mode);
		case (mode)
			0: return DATA_W'(int'($urandom_range(0, 20)) - 10);
			1: case ($urandom_range(0, 5))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return VAL_MIN + 1;
				3: return VAL_MAX - 1;
				4: return '1;
				default: return '0;
			endcase
			default: return $urandom();
		endcase
	endfunction

	// Random query or restore; query operands land near a recent load value one time in three.
	function automatic void queue_probe(input logic [DATA_W-1:0] near_value, input bit drain);
		logic [DATA_W-1:0] v;
		bit                last;
		last = $urandom_range(0, 1);
		case ($urandom_range(0, 2))
			0: v = near_value + DATA_W'(int'($urandom_range(0, 2)) - 1);
			1: v = pick_value($urandom_range(0, 1));
			default: v = $urandom();
		endcase
		case ($urandom_range(0, 2))
			0: queue_item(CMD_LOWER, v, last, drain);
			1: queue_item(CMD_UPPER, v, last, drain);
			default: queue_item(CMD_RESTORE,
				($urandom_range(0, 5) == 0) ? $urandom() : DATA_W'($urandom_range(0, 70)),
				last, drain);
		endcase
	endfunction

	// Queue one batch of n loads, with stray probes inside it now and then.
	function automatic void queue_batch(input int n, input bit drain);
		int                mode;
		logic [DATA_W-1:0] v;
		mode = $urandom_range(0, 2);
		for (int i = 0; i < n; i++) begin
			v = pick_value(($urandom_range(0, 7) == 0) ? 1 : mode);
			queue_item(CMD_LOAD, v, i == n - 1, drain && i == 0);
			if (i < n - 1 && $urandom_range(0, 9) == 0)
				queue_probe(v, 1'b0);
		end
	endfunction

	function automatic void build_stimulus();
		int                directed;
		int                n;
		bit                drain;
		logic [DATA_W-1:0] last_v;

		// Queries on an empty list.
		queue_item(CMD_LOWER, '0, 1'b0, 1'b0);
		queue_item(CMD_UPPER, VAL_MIN, 1'b0, 1'b0);
		queue_item(CMD_RESTORE, '0, 1'b0, 1'b0);
		// Batch with both extremes, zero, minus one and a duplicate.
		queue_item(CMD_LOAD, VAL_MAX, 1'b0, 1'b0);
		queue_item(CMD_LOAD, VAL_MIN, 1'b0, 1'b0);
		queue_item(CMD_LOAD, '0, 1'b0, 1'b0);
		queue_item(CMD_LOAD, '1, 1'b0, 1'b0);
		queue_item(CMD_LOAD, VAL_MAX, 1'b0, 1'b0);
		queue_item(CMD_LOAD, 32'd5, 1'b1, 1'b0);
		// batch_end on a query is ignored.
		queue_item(CMD_LOWER, VAL_MIN, 1'b1, 1'b0);
		queue_item(CMD_UPPER, VAL_MIN, 1'b0, 1'b0);
		queue_item(CMD_LOWER, VAL_MAX, 1'b0, 1'b0);
		queue_item(CMD_UPPER, VAL_MAX, 1'b1, 1'b0);
		// Restores: first, last, just past the end, negative, huge.
		queue_item(CMD_RESTORE, '0, 1'b0, 1'b0);
		queue_item(CMD_RESTORE, 32'd4, 1'b0, 1'b0);
		queue_item(CMD_RESTORE, 32'd5, 1'b0, 1'b0);
		queue_item(CMD_RESTORE, '1, 1'b1, 1'b0);
		queue_item(CMD_RESTORE, VAL_MAX, 1'b0, 1'b0);
		// Single-value batch, sent only after everything has drained.
		queue_item(CMD_LOAD, 32'd42, 1'b1, 1'b1);
		// Probes while a batch is still open, then close on a duplicate.
		queue_item(CMD_LOAD, 32'd7, 1'b0, 1'b0);
		queue_item(CMD_UPPER, 32'd7, 1'b0, 1'b0);
		queue_item(CMD_RESTORE, '0, 1'b1, 1'b0);
		queue_item(CMD_LOAD, 32'd7, 1'b1, 1'b0);
		directed = queued_items.size();

		// One full batch and one that runs past capacity, then random episodes.
		queue_batch(MAX_ITEMS, 1'b1);
		queue_probe('0, 1'b0);
		queue_batch(MAX_ITEMS + 3, 1'b0);
		last_v = '0;
		while (queued_items.size() < directed + RANDOM_ITEMS) begin
			drain = ($urandom_range(0, 39) == 0);
			if ($urandom_range(0, 99) < 60) begin
				case ($urandom_range(0, 29))
					0:       n = $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6);
					1, 2, 3: n = $urandom_range(9, 20);
					default: n = $urandom_range(1, 8);
				endcase
				queue_batch(n, drain);
				last_v = queued_items[$ - ($urandom_range(0, 1))].operand;
				repeat ($urandom_range(1, 4))
					queue_probe(last_v, 1'b0);
			end else begin
				queue_probe(last_v, drain);
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: present queued items; hold valid and payload until accepted.
	// Idle in bursts only between transactions, never while valid is up.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			item_fire = item_valid && item_ready;
			if (item_fire) begin
				predict_results(item);
				void'(queued_items.pop_front());
				void'(hold_for_drain.pop_front());
				items_sent++;
			end
			if (!(item_valid && !item_fire)) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (queued_items.size() == 0) begin
					item_valid <= 1'b0;
				end else if (hold_for_drain[0] && expected_answers.size() != 0) begin
					// hold off until every outstanding result is back
					item_valid <= 1'b0;
				end else if (queued_items.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(1, 14) - 1;
					item_valid <= 1'b0;
				end else begin
					item       <= queued_items[0];
					item_valid <= 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check each accepted result against the oldest expectation,
	// and stall the result channel in random bursts.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_answers.size() == 0) begin
					report_mismatch($sformatf("unexpected result answer=%0d run_end=%0b overflow=%0b",
						result.answer, result.run_end, result.overflow));
				end else begin
					if (result.answer !== expected_answers[0].answer)
						report_mismatch($sformatf("answer %0d, expected %0d",
							result.answer, expected_answers[0].answer));
					if (result.run_end !== expected_answers[0].run_end)
						report_mismatch($sformatf("run_end %0b, expected %0b",
							result.run_end, expected_answers[0].run_end));
					if (result.overflow !== expected_answers[0].overflow)
						report_mismatch($sformatf("overflow %0b, expected %0b",
							result.overflow, expected_answers[0].overflow));
					void'(expected_answers.pop_front());
				end
				results_checked++;
			end
			if (recv_gap > 0) begin
				recv_gap--;
				result_ready <= 1'b0;
			end else if (queued_items.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(1, 14) - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Count cycles in which neither channel completes an expected transaction;
	// a stream of unexpected results does not keep the run alive.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) ||
			    (result_valid && result_ready && expected_answers.size() != 0))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
			QUIET_LIMIT, expected_answers.size());
		$display("coordinate_compressor_unit test failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence: build stimulus, reset once, drain, settle, report.
	// ------------------------------------------------------------------
	initial begin
		build_stimulus();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (queued_items.size() != 0 || item_valid || expected_answers.size() != 0)
			@(posedge clk);
		// watch for stray results after the last expected one
		repeat (END_SETTLE) @(posedge clk);
		$display("Covered %0d item transactions, %0d results checked, %0d mismatches.",
			items_sent, results_checked, mismatches);
		$display("Closed %0d load batches, %0d of them cut at capacity.",
			batches_closed, batches_cut);
		if (mismatches == 0 && expected_answers.size() == 0)
			$display("coordinate_compressor_unit test passed");
		else
			$display("coordinate_compressor_unit test failed");
		$finish;
	end

endmodule
